/* sv/thdf_pkg.sv */
package thdf_pkg;

    // Bytes strictly between these two values feed the hash.
    localparam logic [7:0] LOW_EXCL  = 8'h41;
    localparam logic [7:0] HIGH_EXCL = 8'h7A;
    localparam logic [7:0] END_BYTE  = 8'h00;

    localparam int HASH_MULT = 23;

    // The bitmap is stored as rows of WORD_W bits.
    localparam int WORD_SH = 6;
    localparam int WORD_W  = 1 << WORD_SH;

    // Result queue depth: covers the lookup in flight plus two waiting results.
    localparam int OUTQ_DEPTH = 3;
    localparam int OUTQ_CW    = 2;

    typedef struct packed {
        logic clr_busy;
        logic room;
    } t_front_ctl;

endpackage

/* sv/thdf_ram.sv */
module thdf_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16384,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // A read at the address being written returns the old contents.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* sv/thdf_front.sv */
module thdf_front #(
    parameter int TABLE_BITS = 1048576,
    parameter int HASH_W     = $clog2(TABLE_BITS)
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [7:0]          i_doc_byte,
    input  thdf_pkg::t_front_ctl i_ctl,
    output logic                o_fire,
    output logic [HASH_W-1:0]   o_hash
);

    localparam longint unsigned XMAX =
        64'(thdf_pkg::HASH_MULT) * (64'(TABLE_BITS) - 64'd1) + 64'(thdf_pkg::HIGH_EXCL) - 64'd1;
    localparam int X_W  = $clog2(XMAX + 64'd1);
    localparam int QMAX = int'(XMAX / 64'(TABLE_BITS));
    localparam bit POW2 = ((TABLE_BITS & (TABLE_BITS - 1)) == 0);

    logic              r_s1_vld;
    logic [7:0]        r_s1_byte;
    logic [HASH_W-1:0] r_hash;
    logic [HASH_W-1:0] n_hash;
    logic [X_W-1:0]    prod;
    logic [X_W-1:0]    sub;
    logic              s1_end;
    logic              s1_count;
    logic              s1_go;
    logic              accept;

    assign s1_end   = (r_s1_byte == thdf_pkg::END_BYTE);
    assign s1_count = (r_s1_byte > thdf_pkg::LOW_EXCL) && (r_s1_byte < thdf_pkg::HIGH_EXCL);
    // An end byte leaves only when the result queue is sure to have a slot.
    assign s1_go    = r_s1_vld && (!s1_end || i_ctl.room);
    assign o_in_ready = !i_ctl.clr_busy && (!r_s1_vld || s1_go);
    assign accept   = i_in_valid && o_in_ready;

    assign prod = X_W'(r_hash) * X_W'(thdf_pkg::HASH_MULT) + X_W'(r_s1_byte);

    // The sum stays below (QMAX+1)*TABLE_BITS, so the quotient is found by
    // comparing against each multiple in parallel.
    always_comb begin
        sub = '0;
        if (!POW2) begin
            for (int k = 1; k <= QMAX; k++) begin
                if (prod >= X_W'(64'(k) * 64'(TABLE_BITS))) begin
                    sub = X_W'(64'(k) * 64'(TABLE_BITS));
                end
            end
        end
    end

    assign n_hash = HASH_W'(prod - sub);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_hash   <= '0;
        end else begin
            if (accept) begin
                r_s1_vld <= 1'b1;
            end else if (s1_go) begin
                r_s1_vld <= 1'b0;
            end
            if (s1_go) begin
                if (s1_end) begin
                    r_hash <= '0;
                end else if (s1_count) begin
                    r_hash <= n_hash;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_byte <= i_doc_byte;
        end
    end

    assign o_fire = s1_go && s1_end;
    assign o_hash = r_hash;

endmodule

/* sv/thdf_outq.sv */
module thdf_outq (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_push,
    input  logic                          i_data,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic                          o_data,
    output logic [thdf_pkg::OUTQ_CW-1:0]  o_count
);

    localparam int PW = (thdf_pkg::OUTQ_DEPTH > 2) ? $clog2(thdf_pkg::OUTQ_DEPTH) : 1;

    logic                         r_mem [thdf_pkg::OUTQ_DEPTH];
    logic [PW-1:0]                r_wptr;
    logic [PW-1:0]                r_rptr;
    logic [thdf_pkg::OUTQ_CW-1:0] r_count;
    logic                         pop;

    assign o_out_valid = (r_count != '0);
    assign pop         = o_out_valid && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= (r_wptr == PW'(thdf_pkg::OUTQ_DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (pop) begin
                r_rptr <= (r_rptr == PW'(thdf_pkg::OUTQ_DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            case ({i_push, pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    assign o_data  = r_mem[r_rptr];
    assign o_count = r_count;

endmodule

/* sv/text_hash_duplicate_filter.sv */
// Channel   Valid         Ready         Payload
// in        i_in_valid    o_in_ready    i_doc_byte[7:0]
// out       o_out_valid   i_out_ready   o_is_new
//
// One byte is taken per cycle while o_in_ready is high; an end byte's result passes
// through the input register, the bitmap row read and the result queue.
// After reset the bitmap is cleared one 64-bit row per cycle, all ceil(TABLE_BITS/64)
// rows (16384 at the default), while o_in_ready stays low.
// A stalled output stops only end bytes, once three results are pending or in flight.
module text_hash_duplicate_filter #(
    parameter int TABLE_BITS = 1048576
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_doc_byte,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic       o_is_new
);

    localparam int HASH_W = $clog2(TABLE_BITS);
    localparam int ROWS   = (TABLE_BITS + thdf_pkg::WORD_W - 1) / thdf_pkg::WORD_W;
    localparam int ROW_AW = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int IDX_W  = (HASH_W > thdf_pkg::WORD_SH) ? HASH_W : thdf_pkg::WORD_SH;

    thdf_pkg::t_front_ctl         front_ctl;
    logic                         fire;
    logic [HASH_W-1:0]            hash;
    logic [IDX_W-1:0]             hash_ext;
    logic [ROW_AW-1:0]            look_row;

    logic                         r_clr_busy;
    logic [ROW_AW-1:0]            r_clr_addr;

    logic                         r_s2_vld;
    logic [ROW_AW-1:0]            r_s2_row;
    logic [thdf_pkg::WORD_SH-1:0] r_s2_bit;

    logic                         r_wr_vld;
    logic [ROW_AW-1:0]            r_wr_row;
    logic [thdf_pkg::WORD_W-1:0]  r_wr_data;

    logic [thdf_pkg::WORD_W-1:0]  ram_rdata;
    logic [thdf_pkg::WORD_W-1:0]  merged;
    logic [thdf_pkg::WORD_W-1:0]  set_data;
    logic                         was_set;
    logic                         ram_we;
    logic [ROW_AW-1:0]            ram_waddr;
    logic [thdf_pkg::WORD_W-1:0]  ram_wdata;
    logic [thdf_pkg::OUTQ_CW-1:0] q_count;

    assign front_ctl.clr_busy = r_clr_busy;
    assign front_ctl.room     = ({1'b0, q_count} + {{thdf_pkg::OUTQ_CW{1'b0}}, r_s2_vld})
                                < (thdf_pkg::OUTQ_CW + 1)'(thdf_pkg::OUTQ_DEPTH);

    thdf_front #(
        .TABLE_BITS (TABLE_BITS),
        .HASH_W     (HASH_W)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_doc_byte (i_doc_byte),
        .i_ctl      (front_ctl),
        .o_fire     (fire),
        .o_hash     (hash)
    );

    assign hash_ext = IDX_W'(hash);
    assign look_row = ROW_AW'(hash_ext >> thdf_pkg::WORD_SH);

    // The row read for this lookup misses only the write made in the same
    // cycle as the read, so that one write is forwarded.
    assign merged   = (r_wr_vld && (r_wr_row == r_s2_row)) ? r_wr_data : ram_rdata;
    assign was_set  = merged[r_s2_bit];
    assign set_data = merged | (thdf_pkg::WORD_W'(1) << r_s2_bit);

    assign ram_we    = r_clr_busy || r_s2_vld;
    assign ram_waddr = r_clr_busy ? r_clr_addr : r_s2_row;
    assign ram_wdata = r_clr_busy ? '0 : set_data;

    thdf_ram #(
        .WIDTH (thdf_pkg::WORD_W),
        .DEPTH (ROWS),
        .AW    (ROW_AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (fire),
        .i_raddr (look_row),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
            r_s2_vld   <= 1'b0;
            r_wr_vld   <= 1'b0;
        end else begin
            if (r_clr_busy) begin
                if (r_clr_addr == ROW_AW'(ROWS - 1)) begin
                    r_clr_busy <= 1'b0;
                end
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            r_s2_vld <= fire;
            r_wr_vld <= r_s2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_s2_row <= look_row;
            r_s2_bit <= hash_ext[thdf_pkg::WORD_SH-1:0];
        end
        if (r_s2_vld) begin
            r_wr_row  <= r_s2_row;
            r_wr_data <= set_data;
        end
    end

    thdf_outq u_outq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (r_s2_vld),
        .i_data      (!was_set),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_data      (o_is_new),
        .o_count     (q_count)
    );

endmodule
